FILE: src/iirl_pkg.sv
// Package for the indexed insert/remove list.
// Holds the operation codes, shared widths and the cell command struct.
// No dependencies.
package iirl_pkg;

    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 8;
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried on the op field
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2
    } t_op;

    // Broadcast command seen by every cell in the row
    typedef struct packed {
        logic ins;   // insert succeeds this cycle
        logic rem;   // remove succeeds this cycle
    } t_cell_cmd;

endpackage

FILE: src/indexed_insert_remove_list.sv
// Indexed insert/remove list: a row of CAPACITY cells, one entry each.
// The result strobe o_done rises in the cycle after start is taken.
// Throughput: one transaction per cycle unless busy; every cell shifts
// in parallel; the read port selects a cell by AND-OR over the row.
// Reset (synchronous, active low) empties the list; busy is high during
// reset. The receiver cannot stall; o_done is high for one cycle.
module indexed_insert_remove_list #(
    parameter int CAPACITY = iirl_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_op,
    input  logic [iirl_pkg::INDEX_W-1:0]  i_index,
    input  logic signed [iirl_pkg::DATA_W-1:0] i_value,
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_ok,
    output logic signed [iirl_pkg::DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]              o_count
);
    import iirl_pkg::*;

    // Compare width covers both the index field and the fill count
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [DATA_W-1:0] w_word [CAPACITY];
    logic [DATA_W-1:0] w_left [CAPACITY];
    logic [DATA_W-1:0] w_right[CAPACITY];

    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             r_ok;
    logic [DATA_W-1:0] r_rd;

    logic              w_take;
    logic [CMP_W-1:0]  w_idx;
    logic [CMP_W-1:0]  w_cnt;
    logic [CMP_W-1:0]  w_pos;
    logic              w_in_range;
    logic              w_is_ins;
    logic              w_is_rem;
    logic              w_is_peek;
    logic              w_ok;
    logic [DATA_W-1:0] w_pick;
    t_cell_cmd         w_cmd;

    assign w_take = i_start && !r_busy;
    assign w_idx  = CMP_W'(i_index);
    assign w_cnt  = CMP_W'(r_count);

    // Decode the operation and its success
    always_comb begin
        w_is_ins   = (i_op == OP_INSERT);
        w_is_rem   = (i_op == OP_REMOVE);
        w_is_peek  = (i_op == OP_PEEK);
        w_in_range = (w_idx < w_cnt);
        w_cmd.ins  = w_take && w_is_ins && (r_count < CAP_C);
        w_cmd.rem  = w_take && w_is_rem && w_in_range;
        w_ok       = w_cmd.ins || w_cmd.rem || (w_is_peek && w_in_range);
        // insert past the end appends at the fill count
        w_pos      = (w_is_ins && !w_in_range) ? w_cnt : w_idx;
    end

    // Read select: AND-OR of every cell against the index
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_idx == CMP_W'(i)) begin
                w_pick = w_pick | w_word[i];
            end
        end
    end

    // Neighbor wiring along the row
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_left[i]  = (i == 0) ? '0 : w_word[(i == 0) ? 0 : i - 1];
            w_right[i] = (i == CAPACITY - 1) ? '0
                       : w_word[(i == CAPACITY - 1) ? i : i + 1];
        end
    end

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iirl_cell #(
            .POS_W (CMP_W),
            .POS   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_value (i_value),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_word  (w_word[g])
        );
    end

    // Fill count update
    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_count <= n_count;
            r_done  <= w_take;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ok <= w_ok;
            r_rd <= (w_ok && !w_is_ins) ? w_pick : '0;
        end
    end

    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_count      = r_count;

endmodule

FILE: src/iirl_cell.sv
// One storage cell of the list row: holds a single entry.
// Loads the new word, takes its left neighbor's word on insert or its
// right neighbor's word on remove. Depends on iirl_pkg.
module iirl_cell #(
    parameter int POS_W = 8,
    parameter int POS   = 0
) (
    input  logic                         i_clk,
    input  iirl_pkg::t_cell_cmd          i_cmd,
    input  logic [POS_W-1:0]             i_pos,
    input  logic [iirl_pkg::DATA_W-1:0]  i_value,
    input  logic [iirl_pkg::DATA_W-1:0]  i_left,
    input  logic [iirl_pkg::DATA_W-1:0]  i_right,
    output logic [iirl_pkg::DATA_W-1:0]  o_word
);
    import iirl_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [DATA_W-1:0] r_word;
    logic [DATA_W-1:0] n_word;

    // Next entry: insert point loads, cells above it shift up;
    // on remove, cells at and above the point shift down
    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (MY_POS == i_pos) begin
                n_word = i_value;
            end else if (MY_POS > i_pos) begin
                n_word = i_left;
            end
        end else if (i_cmd.rem) begin
            if (MY_POS >= i_pos) begin
                n_word = i_right;
            end
        end
    end

    // Payload only, no reset needed
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
